### sv/assert_macros.svh
// assertion macros used by the tracker core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define CTT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on the next edge
`define CTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ctt_pkg.sv
// types and constants of the clique tightness tracker
package ctt_pkg;

   localparam int MAX_V     = 256;
   localparam int VW        = $clog2(MAX_V);
   localparam int CW        = $clog2(MAX_V + 1);
   localparam int FREQ_BITS = 16;

   localparam logic [2:0] OP_ADD_EDGE    = 3'd0;
   localparam logic [2:0] OP_ADD_VERTEX  = 3'd1;
   localparam logic [2:0] OP_DEL_VERTEX  = 3'd2;
   localparam logic [2:0] OP_QUERY       = 3'd3;
   localparam logic [2:0] OP_RESTART     = 3'd4;
   localparam logic [2:0] OP_CLEAR_GRAPH = 3'd5;

   localparam logic [1:0] STS_DONE    = 2'd0;
   localparam logic [1:0] STS_IGNORED = 2'd1;
   localparam logic [1:0] STS_RANGE   = 2'd2;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] vertex;
      logic [7:0] other_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        vertex_in_clique;
      logic [7:0]  vertex_tightness;
      logic [15:0] vertex_frequency;
      logic [8:0]  clique_size;
      logic [8:0]  free_count;
      logic [8:0]  one_miss_count;
   } rsp_type;

   typedef struct packed {
      logic                 member;
      logic [7:0]           tight;
      logic [FREQ_BITS-1:0] freq;
   } vtx_entry_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_DISPATCH, ST_CHK, ST_WALK, ST_EDGE1, ST_EDGE2,
      ST_CLRADJ, ST_CLRVTX, ST_OUTRD, ST_OUTCAP
   } state_type;

endpackage

### sv/clique_tightness_tracker_core.sv
// clique tightness tracker top level
//
//  channel | ports           | direction | payload
//  req     | req_valid/ready | in        | req_type: op, vertex, other_vertex
//  rsp     | rsp_valid/ready | out       | rsp_type: status, vertex fields, totals
//  csr     | csr_we/wdata    | in        | vertex_count, 9 bits
//
// add and remove vertex run the vertex ram read-modify-write walk over the active
// vertices, one vertex entry per cycle. add edge sets a bit in both adjacency rows,
// query reads the vertex entry, restart and clear graph clear one ram row per cycle.
// after reset a clearing pass runs over all 256 rows of both rams; no beat is taken.
// a stalled rsp beat holds the block before it returns to idle.
`include "assert_macros.svh"
module clique_tightness_tracker_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctt_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [8:0]       csr_wdata
);
   import ctt_pkg::*;

   state_type     state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [VW-1:0] v_ff, v_in, w_ff, w_in;
   logic [1:0]    status_ff, status_in;
   logic [CW-1:0] active_ff, active_in, vcount_ff;
   logic [CW-1:0] members_ff, members_in, free_ff, free_in, onemiss_ff, onemiss_in;
   logic [CW-1:0] u_ff, u_in;
   logic          p_valid_ff, p_valid_in;
   logic [VW-1:0] p_idx_ff, p_idx_in;
   logic [MAX_V-1:0] row_ff, row_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic             vw_en, aw_en;
   logic [VW-1:0]    vw_addr, vr_addr, aw_addr, ar_addr;
   vtx_entry_type    vw_data, vr_data;
   logic [MAX_V-1:0] aw_data, ar_data;
   logic [CW-1:0]    graph_n;
   vtx_entry_type    e;
   logic             v_in_range;

   ctt_ram #(.WIDTH($bits(vtx_entry_type)), .DEPTH(MAX_V)) u_vtx_ram (
      .clock(clock), .wr_en(vw_en), .wr_addr(vw_addr), .wr_data(vw_data),
      .rd_addr(vr_addr), .rd_data(vr_data)
   );

   ctt_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V)) u_adj_ram (
      .clock(clock), .wr_en(aw_en), .wr_addr(aw_addr), .wr_data(aw_data),
      .rd_addr(ar_addr), .rd_data(ar_data)
   );

   assign graph_n    = (vcount_ff > CW'(MAX_V)) ? CW'(MAX_V) : vcount_ff;
   assign v_in_range = {1'b0, v_ff} < active_ff;
   assign e          = vr_data;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CW'(MAX_V);
      end else if (csr_we) begin
         vcount_ff <= csr_wdata;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         active_ff    <= CW'(MAX_V);
         members_ff   <= '0;
         free_ff      <= CW'(MAX_V);
         onemiss_ff   <= '0;
         u_ff         <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         members_ff   <= members_in;
         free_ff      <= free_in;
         onemiss_ff   <= onemiss_in;
         u_ff         <= u_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      v_ff      <= v_in;
      w_ff      <= w_in;
      status_ff <= status_in;
      p_idx_ff  <= p_idx_in;
      row_ff    <= row_in;
      rsp_ff    <= rsp_in;
   end

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      status_in    = status_ff;
      active_in    = active_ff;
      members_in   = members_ff;
      free_in      = free_ff;
      onemiss_in   = onemiss_ff;
      u_in         = u_ff;
      p_valid_in   = 1'b0;
      p_idx_in     = p_idx_ff;
      row_in       = row_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      vw_en        = 1'b0;
      vw_addr      = v_ff;
      vw_data      = '0;
      vr_addr      = v_ff;
      aw_en        = 1'b0;
      aw_addr      = v_ff;
      aw_data      = '0;
      ar_addr      = v_ff;

      case (state_ff)
         // clear both rams after reset
         ST_INIT: begin
            vw_en   = 1'b1;
            vw_addr = u_ff[VW-1:0];
            aw_en   = 1'b1;
            aw_addr = u_ff[VW-1:0];
            u_in    = u_ff + 1'b1;
            if (u_ff == CW'(MAX_V - 1)) begin
               u_in     = '0;
               state_in = ST_IDLE;
            end
         end
         // take a request beat
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.op;
               v_in      = req_data.vertex;
               w_in      = req_data.other_vertex;
               status_in = STS_DONE;
               state_in  = ST_DISPATCH;
            end
         end
         // range checks, first reads
         ST_DISPATCH: begin
            vr_addr  = v_ff;
            ar_addr  = v_ff;
            state_in = ST_OUTRD;
            case (op_ff)
               OP_ADD_EDGE: begin
                  if ({1'b0, v_ff} >= graph_n || {1'b0, w_ff} >= graph_n) begin
                     status_in = STS_RANGE;
                  end else if (v_ff == w_ff) begin
                     status_in = STS_IGNORED;
                  end else begin
                     state_in = ST_EDGE1;
                  end
               end
               OP_ADD_VERTEX, OP_DEL_VERTEX: begin
                  if (!v_in_range) begin
                     status_in = STS_RANGE;
                  end else begin
                     state_in = ST_CHK;
                  end
               end
               OP_QUERY: begin
                  if (!v_in_range) begin
                     status_in = STS_RANGE;
                  end
               end
               OP_RESTART: begin
                  active_in  = graph_n;
                  members_in = '0;
                  free_in    = graph_n;
                  onemiss_in = '0;
                  u_in       = '0;
                  state_in   = ST_CLRVTX;
               end
               OP_CLEAR_GRAPH: begin
                  u_in     = '0;
                  state_in = ST_CLRADJ;
               end
               default: begin
                  status_in = STS_IGNORED;
               end
            endcase
         end
         // check the vertex entry and update it
         ST_CHK: begin
            row_in   = ar_data;
            u_in     = '0;
            state_in = ST_WALK;
            vw_en    = 1'b1;
            vw_addr  = v_ff;
            vw_data  = e;
            if (op_ff == OP_ADD_VERTEX) begin
               if (e.member || e.tight != 8'd0) begin
                  vw_en     = 1'b0;
                  status_in = STS_IGNORED;
                  state_in  = ST_OUTRD;
               end else begin
                  vw_data.member = 1'b1;
                  if (e.freq != '1) begin
                     vw_data.freq = e.freq + 1'b1;
                  end
                  members_in = members_ff + 1'b1;
                  free_in    = free_ff - 1'b1;
               end
            end else begin
               if (!e.member) begin
                  vw_en     = 1'b0;
                  status_in = STS_IGNORED;
                  state_in  = ST_OUTRD;
               end else begin
                  vw_data.member = 1'b0;
                  vw_data.tight  = 8'd0;
                  members_in     = members_ff - 1'b1;
                  free_in        = free_ff + 1'b1;
               end
            end
         end
         // read-modify-write walk over the other vertices
         ST_WALK: begin
            if (u_ff < active_ff) begin
               vr_addr    = u_ff[VW-1:0];
               p_valid_in = 1'b1;
               p_idx_in   = u_ff[VW-1:0];
               u_in       = u_ff + 1'b1;
            end else if (!p_valid_ff) begin
               state_in = ST_OUTRD;
            end
            if (p_valid_ff && p_idx_ff != v_ff && !e.member && !row_ff[p_idx_ff]) begin
               vw_addr = p_idx_ff;
               vw_data = e;
               if (op_ff == OP_ADD_VERTEX) begin
                  vw_en = 1'b1;
                  if (e.tight != 8'hff) begin
                     vw_data.tight = e.tight + 1'b1;
                  end
                  if (e.tight == 8'd0) begin
                     free_in    = free_ff - 1'b1;
                     onemiss_in = onemiss_ff + 1'b1;
                  end else if (e.tight == 8'd1) begin
                     onemiss_in = onemiss_ff - 1'b1;
                  end
               end else if (e.tight != 8'd0) begin
                  vw_en         = 1'b1;
                  vw_data.tight = e.tight - 1'b1;
                  if (e.tight == 8'd1) begin
                     onemiss_in = onemiss_ff - 1'b1;
                     free_in    = free_ff + 1'b1;
                  end else if (e.tight == 8'd2) begin
                     onemiss_in = onemiss_ff + 1'b1;
                  end
               end
            end
         end
         // row v is back: test and set bit w, read row w
         ST_EDGE1: begin
            if (ar_data[w_ff]) begin
               status_in = STS_IGNORED;
               state_in  = ST_OUTRD;
            end else begin
               aw_en           = 1'b1;
               aw_addr         = v_ff;
               aw_data         = ar_data;
               aw_data[w_ff]   = 1'b1;
               ar_addr         = w_ff;
               state_in        = ST_EDGE2;
            end
         end
         // set bit v of row w
         ST_EDGE2: begin
            aw_en         = 1'b1;
            aw_addr       = w_ff;
            aw_data       = ar_data;
            aw_data[v_ff] = 1'b1;
            state_in      = ST_OUTRD;
         end
         // clearing pass over the adjacency rows
         ST_CLRADJ: begin
            aw_en   = 1'b1;
            aw_addr = u_ff[VW-1:0];
            u_in    = u_ff + 1'b1;
            if (u_ff == CW'(MAX_V - 1)) begin
               state_in = ST_OUTRD;
            end
         end
         // clearing pass over the vertex entries
         ST_CLRVTX: begin
            vw_en   = 1'b1;
            vw_addr = u_ff[VW-1:0];
            u_in    = u_ff + 1'b1;
            if (u_ff == CW'(MAX_V - 1)) begin
               state_in = ST_OUTRD;
            end
         end
         // read the vertex entry for the response
         ST_OUTRD: begin
            vr_addr  = v_ff;
            state_in = ST_OUTCAP;
         end
         // load the response beat once the output slot is free
         ST_OUTCAP: begin
            vr_addr = v_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status           = status_ff;
               rsp_in.vertex_in_clique = v_in_range ? e.member : 1'b0;
               rsp_in.vertex_tightness = v_in_range ? e.tight : 8'd0;
               rsp_in.vertex_frequency = v_in_range ? 16'(e.freq) : 16'd0;
               rsp_in.clique_size      = members_ff;
               rsp_in.free_count       = free_ff;
               rsp_in.one_miss_count   = onemiss_ff;
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // checks
   `CTT_ASSERT_ALWAYS(a_members_le_active, members_ff <= active_ff,
      "clique size above active vertex count")
   `CTT_ASSERT_ALWAYS(a_totals_le_active,
      ({1'b0, members_ff} + {1'b0, free_ff} + {1'b0, onemiss_ff}) <= {1'b0, active_ff},
      "vertex totals exceed active vertex count")
   `CTT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
      "request taken while another is in flight")
   `CTT_ASSERT_NEXT(a_walk_bounded, state_ff == ST_WALK && p_valid_ff,
      p_idx_ff < 8'(active_ff - 1'b1) || !p_valid_ff || active_ff == CW'(MAX_V)
      || p_idx_ff == 8'(active_ff - 1'b1),
      "walk went past the active vertices")
endmodule

### sv/ctt_ram.sv
// generic simple dual port ram with registered read
module ctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
